@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk_sig, rst_n_sig, prop) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) \
		else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk_sig, rst_n_sig, expr) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) !(expr)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk_sig, rst_n_sig, prop)
`define ASSERT_NEVER(lbl, clk_sig, rst_n_sig, expr)

`endif

`endif

@@ sv/fbrm_pkg.sv @@
// ----------------------------------------------------------------------------
// fbrm_pkg
// shared types and constants of the frame buffer rotation manager
// ----------------------------------------------------------------------------
package fbrm_pkg;

	localparam int unsigned FUNC_W  = 3;
	localparam int unsigned IDX_W   = 2;
	localparam int unsigned MAP_W   = 4;
	localparam int unsigned CNT_W   = 32;
	localparam int unsigned IN_W    = 8;
	localparam int unsigned OUT_W   = 112;
	localparam int unsigned OUT_PAD = OUT_W - (1 + IDX_W + 1 + IDX_W + MAP_W + 3 * CNT_W);

	// event codes
	typedef enum logic [FUNC_W-1:0] {
		FN_CLAIM   = 3'd0,
		FN_SUBMIT  = 3'd1,
		FN_PRESENT = 3'd2,
		FN_FLUSH   = 3'd3,
		FN_REFRESH = 3'd4
	} func_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
	} cmd_t;

	// result item, last field (granted) in the lowest bits
	typedef struct packed {
		logic [OUT_PAD-1:0] pad;
		logic [CNT_W-1:0]   refreshed_count;
		logic [CNT_W-1:0]   superseded_count;
		logic [CNT_W-1:0]   presented_count;
		logic [MAP_W-1:0]   free_map;
		logic [IDX_W-1:0]   shown_index;
		logic               shown_new;
		logic [IDX_W-1:0]   grant_index;
		logic               granted;
	} result_t;

endpackage

@@ sv/fbrm_ctrl.sv @@
// ----------------------------------------------------------------------------
// fbrm_ctrl
// sequencer: accept an item, execute it, hold the result until taken
// ----------------------------------------------------------------------------
module fbrm_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output fbrm_pkg::cmd_t  cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	// idle, and result register is free or being emptied this cycle
	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign cmd       = '{load: in_valid && in_ready, exec: (state_q == ST_EXEC)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (out_valid_q && out_ready) begin
						out_valid_q <= 1'b0;
					end
					if (in_valid && in_ready) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ sv/fbrm_dp.sv @@
// ----------------------------------------------------------------------------
// fbrm_dp
// buffer pool state, event execution and result register
// ----------------------------------------------------------------------------
module fbrm_dp #(
	parameter int unsigned BUFFERS = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic                           cfg_wr_data,
	input  fbrm_pkg::cmd_t                 cmd,
	input  logic [fbrm_pkg::FUNC_W-1:0]    func,
	input  logic [fbrm_pkg::IDX_W-1:0]     buffer_index,
	output fbrm_pkg::result_t              result
);

	localparam int unsigned SEL_W = (BUFFERS > 1) ? $clog2(BUFFERS) : 1;

	logic                          enable_q;
	logic [fbrm_pkg::FUNC_W-1:0]   func_s1;
	logic [fbrm_pkg::IDX_W-1:0]    index_s1;

	logic [BUFFERS-1:0]            free_q, free_d;
	logic [BUFFERS-1:0]            retire_q, retire_d;
	logic                          ready_valid_q, ready_valid_d;
	logic [fbrm_pkg::IDX_W-1:0]    ready_slot_q, ready_slot_d;
	logic                          active_valid_q, active_valid_d;
	logic [fbrm_pkg::IDX_W-1:0]    active_slot_q, active_slot_d;
	logic                          refresh_owed_q, refresh_owed_d;
	logic                          flush_seen_q, flush_seen_d;
	logic [fbrm_pkg::CNT_W-1:0]    presented_q, presented_d;
	logic [fbrm_pkg::CNT_W-1:0]    superseded_q, superseded_d;
	logic [fbrm_pkg::CNT_W-1:0]    refreshed_q, refreshed_d;

	logic                          pick_found;
	logic [SEL_W-1:0]              pick_idx;
	logic                          granted_d;
	logic [SEL_W-1:0]              grant_sel_d;
	logic                          shown_new_d;
	logic [SEL_W+fbrm_pkg::IDX_W-1:0]  grant_ext;
	logic [BUFFERS+fbrm_pkg::MAP_W-1:0] free_ext;

	fbrm_pkg::result_t             result_q;

	// lowest free buffer
	always_comb begin
		pick_found = 1'b0;
		pick_idx   = '0;
		for (int i = BUFFERS - 1; i >= 0; i--) begin
			if (free_q[i]) begin
				pick_found = 1'b1;
				pick_idx   = SEL_W'(i);
			end
		end
	end

	always_comb begin
		free_d          = free_q;
		retire_d        = retire_q;
		ready_valid_d   = ready_valid_q;
		ready_slot_d    = ready_slot_q;
		active_valid_d  = active_valid_q;
		active_slot_d   = active_slot_q;
		refresh_owed_d  = refresh_owed_q;
		flush_seen_d    = flush_seen_q;
		presented_d     = presented_q;
		superseded_d    = superseded_q;
		refreshed_d     = refreshed_q;
		granted_d       = 1'b0;
		grant_sel_d     = '0;
		shown_new_d     = 1'b0;
		unique case (func_s1)
			fbrm_pkg::FN_CLAIM: begin
				if (enable_q && pick_found) begin
					granted_d   = 1'b1;
					grant_sel_d = pick_idx;
					free_d      = free_q & ~(BUFFERS'(1) << pick_idx);
				end
			end
			fbrm_pkg::FN_SUBMIT: begin
				if (32'(index_s1) < BUFFERS) begin
					// displaced ready frame goes straight back to the pool
					if (ready_valid_q) begin
						free_d       = free_q | (BUFFERS'(1) << ready_slot_q);
						superseded_d = superseded_q + fbrm_pkg::CNT_W'(1);
					end
					ready_slot_d  = index_s1;
					ready_valid_d = 1'b1;
				end
			end
			fbrm_pkg::FN_PRESENT: begin
				if (ready_valid_q) begin
					active_slot_d     = ready_slot_q;
					active_valid_d    = 1'b1;
					ready_valid_d     = 1'b0;
					presented_d       = presented_q + fbrm_pkg::CNT_W'(1);
					if (refresh_owed_q) begin
						superseded_d = superseded_q + fbrm_pkg::CNT_W'(1);
					end
					refresh_owed_d    = 1'b1;
					if (active_valid_q) begin
						retire_d = retire_q | (BUFFERS'(1) << active_slot_q);
					end
					shown_new_d       = 1'b1;
				end
			end
			fbrm_pkg::FN_FLUSH: begin
				flush_seen_d = 1'b1;
			end
			fbrm_pkg::FN_REFRESH: begin
				if (flush_seen_q) begin
					flush_seen_d = 1'b0;
					if (refresh_owed_q) begin
						refreshed_d    = refreshed_q + fbrm_pkg::CNT_W'(1);
						refresh_owed_d = 1'b0;
					end
					free_d   = free_q | retire_q;
					retire_d = '0;
				end
			end
			default: begin
			end
		endcase
	end

	assign grant_ext = {fbrm_pkg::IDX_W'(0), grant_sel_d};
	assign free_ext  = {fbrm_pkg::MAP_W'(0), free_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q        <= 1'b0;
			free_q          <= '1;
			retire_q        <= '0;
			ready_valid_q   <= 1'b0;
			ready_slot_q    <= '0;
			active_valid_q  <= 1'b0;
			active_slot_q   <= '0;
			refresh_owed_q  <= 1'b0;
			flush_seen_q    <= 1'b0;
			presented_q     <= '0;
			superseded_q    <= '0;
			refreshed_q     <= '0;
		end else begin
			if (cfg_wr_en) begin
				enable_q <= cfg_wr_data;
			end
			if (cmd.exec) begin
				free_q          <= free_d;
				retire_q        <= retire_d;
				ready_valid_q   <= ready_valid_d;
				ready_slot_q    <= ready_slot_d;
				active_valid_q  <= active_valid_d;
				active_slot_q   <= active_slot_d;
				refresh_owed_q  <= refresh_owed_d;
				flush_seen_q    <= flush_seen_d;
				presented_q     <= presented_d;
				superseded_q    <= superseded_d;
				refreshed_q     <= refreshed_d;
			end
		end
	end

	// item capture and result register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_s1  <= func;
			index_s1 <= buffer_index;
		end
		if (cmd.exec) begin
			result_q.pad              <= '0;
			result_q.granted          <= granted_d;
			result_q.grant_index      <= grant_ext[fbrm_pkg::IDX_W-1:0];
			result_q.shown_new        <= shown_new_d;
			result_q.shown_index      <= active_valid_d ? active_slot_d : '0;
			result_q.free_map         <= free_ext[fbrm_pkg::MAP_W-1:0];
			result_q.presented_count  <= presented_d;
			result_q.superseded_count <= superseded_d;
			result_q.refreshed_count  <= refreshed_d;
		end
	end

	assign result = result_q;

endmodule

@@ sv/frame_buffer_rotation_manager_unit.sv @@
// ----------------------------------------------------------------------------
// frame_buffer_rotation_manager_unit
// mailbox triple buffering over a small pool of frame buffers
// ----------------------------------------------------------------------------
// sequence: the item is accepted, executed in ST_EXEC, then m_tvalid rises
// flow: items are handled one at a time (accept, then execute); a result not yet
//   taken holds s_tready low, the next item may enter in the cycle it is taken
// reset: arst_n clears all buffers to free, empties ready and active slots,
//   clears the counters and leaves the pool disabled
module frame_buffer_rotation_manager_unit #(
	parameter int unsigned BUFFERS = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// enable register write
	input  logic                          cfg_wr_en,
	input  logic                          cfg_wr_data,
	// event items
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [fbrm_pkg::IN_W-1:0]     s_tdata,  // func[2:0], buffer_index[4:3], zero pad
	// result items
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [fbrm_pkg::OUT_W-1:0]    m_tdata   // granted, grant_index, shown_new,
	                                                // shown_index, free_map, presented_count,
	                                                // superseded_count, refreshed_count, pad
);

	fbrm_pkg::cmd_t    cmd;
	fbrm_pkg::result_t result;

	// input fields, first field in the low bits
	logic [fbrm_pkg::FUNC_W-1:0] in_func;
	logic [fbrm_pkg::IDX_W-1:0]  in_buffer_index;

	assign in_func         = s_tdata[fbrm_pkg::FUNC_W-1:0];
	assign in_buffer_index = s_tdata[fbrm_pkg::FUNC_W+fbrm_pkg::IDX_W-1:fbrm_pkg::FUNC_W];

	// sequencing: one item in flight, result register decoupled from input
	fbrm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd)
	);

	// pool state, event handling and counters
	fbrm_dp #(
		.BUFFERS (BUFFERS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.cmd          (cmd),
		.func         (in_func),
		.buffer_index (in_buffer_index),
		.result       (result)
	);

	// packed struct places granted in bit 0
	assign m_tdata = result;

`include "assert_macros.svh"

	// an accepted item's result stays invalid while the item executes, then becomes valid
	`ASSERT_PROP(a_result_timing, clk, arst_n, (s_tvalid && s_tready) |=> !m_tvalid ##1 m_tvalid)
	// a stalled result blocks new items
	`ASSERT_NEVER(a_no_accept_on_stall, clk, arst_n, m_tvalid && !m_tready && s_tready)
	// a taken result is never shown twice
	`ASSERT_PROP(a_single_result, clk, arst_n, (m_tvalid && m_tready) |=> !m_tvalid)

endmodule
